// ===== design/deq_pkg.sv =====
`default_nettype none
package deq_pkg;

   localparam int DEQ_DEPTH = 32;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_LIST       = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               element_valid;
      logic signed [31:0] element;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_RIGHT,
      CELL_SHIFT_LEFT,
      CELL_APPEND,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] value;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words.
// Command channel: req (kind, value) is taken at a clock edge where start is
// high and busy is low. Kinds: push front, push back, pop front, pop back, list.
// Result channel: rsp_strobe marks rsp for exactly one cycle; the receiver
// takes every result as it comes and cannot stall the block.
// Push and pop give one status result in the cycle after the command and
// do not raise busy, so such commands may come every cycle while busy is low.
// A list raises busy and streams every entry front to back, one per cycle,
// with last set on the final one; busy drops with the final result. A list
// of an empty queue gives one empty status.
// A push to a full queue is refused with status full; a pop of an empty one
// gives status empty. Unused kinds are dropped without a result.
// Storage is a row of DEPTH cells; the front word sits in cell 0 and the cells
// shift by loading from their neighbors, so the list walk is a rotation of the row.
// Reset (synchronous) empties the queue and clears busy and the strobe.
`default_nettype none
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire deq_pkg::req_type req,
   output logic                 rsp_strobe,
   output deq_pkg::rsp_type     rsp
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             busy_ff, busy_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;
   cell_ctl_type     ctl;
   logic             accept;
   logic             full, empty;

   logic signed [31:0] cell_data [DEPTH];

   assign accept = start & ~busy_ff;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      count_in  = count_ff;
      left_in   = left_ff;
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      rsp_in    = '{status: STATUS_DONE, element_valid: 1'b0, element: '0, last: 1'b1};
      ctl.op    = CELL_HOLD;
      ctl.value = req.value;
      if (busy_ff) begin
         // stream the front word and turn the row
         strobe_in            = 1'b1;
         rsp_in.element_valid = 1'b1;
         rsp_in.element       = cell_data[0];
         rsp_in.last          = (left_ff == CNT_W'(1));
         ctl.op               = CELL_ROTATE;
         left_in              = left_ff - CNT_W'(1);
         if (left_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end else if (accept) begin
         case (req.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
               strobe_in = 1'b1;
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  ctl.op   = (req.kind == KIND_PUSH_FRONT) ? CELL_SHIFT_RIGHT : CELL_APPEND;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
               strobe_in = 1'b1;
               if (empty) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  if (req.kind == KIND_POP_FRONT) begin
                     ctl.op = CELL_SHIFT_LEFT;
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
            KIND_LIST: begin
               if (empty) begin
                  strobe_in     = 1'b1;
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  busy_in = 1'b1;
                  left_in = count_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         left_ff   <= '0;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         left_ff   <= left_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_w;
      logic signed [31:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = req.value;
      end else begin : g_mid
         assign left_w = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign right_w = cell_data[i];
      end else begin : g_next
         assign right_w = cell_data[i+1];
      end
      deq_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock (clock),
         .ctl   (ctl),
         .count (count_ff),
         .left  (left_w),
         .right (right_w),
         .head  (cell_data[0]),
         .data  (cell_data[i])
      );
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule
`default_nettype wire

// ===== design/deq_cell.sv =====
`default_nettype none
module deq_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 6
) (
   input  wire logic                 clock,
   input  wire deq_pkg::cell_ctl_type ctl,
   input  wire logic [CNT_W-1:0]     count,
   input  wire logic signed [31:0]   left,
   input  wire logic signed [31:0]   right,
   input  wire logic signed [31:0]   head,
   output logic signed [31:0]        data
);
   import deq_pkg::*;

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      case (ctl.op)
         CELL_HOLD:        data_in = data_ff;
         CELL_SHIFT_RIGHT: data_in = left;
         CELL_SHIFT_LEFT:  data_in = right;
         CELL_APPEND:      data_in = (count == CNT_W'(IDX)) ? ctl.value : data_ff;
         // the tail cell takes the front word, so the row turns one place
         CELL_ROTATE:      data_in = (count == CNT_W'(IDX + 1)) ? head : right;
         default:          data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// ===== tb/tb_double_ended_queue.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_double_ended_queue;
   import deq_pkg::*;

   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
   localparam int RANDOM_ITEMS = 330;
   localparam int MAX_PRINTED  = 40;

   typedef struct {
      req_type cmd;
      bit      drain;
   } feed_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp;

   feed_item_type feed_q[$];
   rsp_type       awaited_rsp[$];
   int            feed_total = 0;
   int            issued = 0;
   int            owed = 0;
   int            error_count = 0;
   int            plan_count = 0;

   logic signed [31:0] deque_words [DEQ_DEPTH];
   int                 head_pos = 0;
   int                 word_count = 0;

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (error_count < MAX_PRINTED)
         $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   // Advance the shadow deque by one command and queue the results it causes.
   function automatic int apply_deque_command(input req_type c);
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      case (c.kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (word_count >= DEQ_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               if (c.kind == KIND_PUSH_FRONT) begin
                  head_pos = (head_pos + DEQ_DEPTH - 1) % DEQ_DEPTH;
                  deque_words[head_pos] = c.value;
               end else begin
                  deque_words[(head_pos + word_count) % DEQ_DEPTH] = c.value;
               end
               word_count++;
               r.status = STATUS_DONE;
            end
            awaited_rsp.push_back(r);
            return 1;
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (word_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               if (c.kind == KIND_POP_FRONT)
                  head_pos = (head_pos + 1) % DEQ_DEPTH;
               word_count--;
               r.status = STATUS_DONE;
            end
            awaited_rsp.push_back(r);
            return 1;
         end
         KIND_LIST: begin
            if (word_count == 0) begin
               r.status = STATUS_EMPTY;
               awaited_rsp.push_back(r);
               return 1;
            end
            for (int i = 0; i < word_count; i++) begin
               r.status        = STATUS_DONE;
               r.element_valid = 1'b1;
               r.element       = deque_words[(head_pos + i) % DEQ_DEPTH];
               r.last          = (i == word_count - 1);
               awaited_rsp.push_back(r);
            end
            return word_count;
         end
         default: return 0;
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      logic [31:0] corner [5];
      corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
      if ($urandom_range(7, 0) == 0)
         return corner[$urandom_range(4, 0)];
      return $urandom;
   endfunction

   // Queue one command and track the fill level it leaves behind.
   function automatic void add_cmd(input logic [2:0] kind, input logic [31:0] value,
                                   input bit drain);
      feed_item_type f;
      f.cmd.kind  = kind;
      f.cmd.value = value;
      f.drain     = drain;
      feed_q.push_back(f);
      if ((kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) && plan_count < DEQ_DEPTH)
         plan_count++;
      else if ((kind == KIND_POP_FRONT || kind == KIND_POP_BACK) && plan_count > 0)
         plan_count--;
   endfunction

   function automatic logic [2:0] pick_push();
      return $urandom_range(1, 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
   endfunction

   function automatic logic [2:0] pick_pop();
      return $urandom_range(1, 0) ? KIND_POP_FRONT : KIND_POP_BACK;
   endfunction

   function automatic void build_stimulus();
      int made;
      int mode;
      int span;
      int roll;
      bit drain;
      // directed: empty cases, extreme words, every kind, unused kinds
      add_cmd(KIND_LIST, 32'h0, 1'b0);
      add_cmd(KIND_POP_FRONT, 32'hFFFF_FFFF, 1'b0);
      add_cmd(KIND_POP_BACK, 32'h0, 1'b0);
      add_cmd(KIND_PUSH_BACK, 32'h7FFF_FFFF, 1'b0);
      add_cmd(KIND_PUSH_FRONT, 32'h8000_0000, 1'b0);
      add_cmd(KIND_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
      add_cmd(KIND_PUSH_FRONT, 32'h0, 1'b0);
      add_cmd(KIND_PUSH_BACK, 32'h1, 1'b0);
      add_cmd(KIND_LIST, 32'hFFFF_FFFF, 1'b0);
      add_cmd(KIND_POP_FRONT, 32'h0, 1'b0);
      add_cmd(KIND_POP_BACK, 32'h0, 1'b0);
      add_cmd(KIND_LIST, 32'h0, 1'b0);
      for (logic [3:0] k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
         add_cmd(k[2:0], $urandom, 1'b0);
      add_cmd(KIND_POP_BACK, 32'h0, 1'b0);
      add_cmd(KIND_POP_FRONT, 32'h0, 1'b0);
      add_cmd(KIND_POP_FRONT, 32'h0, 1'b0);
      add_cmd(KIND_LIST, 32'h0, 1'b0);
      add_cmd(KIND_PUSH_FRONT, 32'h5555_5555, 1'b0);
      add_cmd(KIND_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0);
      add_cmd(KIND_LIST, 32'h0, 1'b0);
      add_cmd(KIND_POP_BACK, 32'h0, 1'b0);
      add_cmd(KIND_POP_BACK, 32'h0, 1'b0);
      add_cmd(KIND_POP_BACK, 32'h0, 1'b0);

      // random: fill, empty and churn episodes; first one fills after a drain
      made = 0;
      mode = 0;
      while (made < RANDOM_ITEMS) begin
         drain = (made == 0) || ($urandom_range(3, 0) == 0);
         case (mode)
            0: begin
               while (plan_count < DEQ_DEPTH) begin
                  if ($urandom_range(9, 0) != 0)
                     add_cmd(pick_push(), pick_word(), drain);
                  else if ($urandom_range(1, 0))
                     add_cmd(KIND_LIST, $urandom, drain);
                  else
                     add_cmd(pick_pop(), $urandom, drain);
                  drain = 1'b0;
                  made++;
               end
               span = $urandom_range(3, 1);
               repeat (span) add_cmd(pick_push(), pick_word(), 1'b0);
               add_cmd(KIND_LIST, $urandom, 1'b0);
               made += span + 1;
            end
            1: begin
               while (plan_count > 0) begin
                  if ($urandom_range(9, 0) != 0)
                     add_cmd(pick_pop(), $urandom, drain);
                  else if ($urandom_range(1, 0))
                     add_cmd(KIND_LIST, $urandom, drain);
                  else
                     add_cmd(pick_push(), pick_word(), drain);
                  drain = 1'b0;
                  made++;
               end
               span = $urandom_range(2, 1);
               repeat (span) add_cmd(pick_pop(), $urandom, 1'b0);
               add_cmd(KIND_LIST, $urandom, 1'b0);
               made += span + 1;
            end
            default: begin
               span = $urandom_range(40, 20);
               repeat (span) begin
                  roll = $urandom_range(99, 0);
                  if (roll < 42) begin
                     add_cmd(pick_push(), pick_word(), drain);
                     made++;
                  end else if (roll < 80) begin
                     add_cmd(pick_pop(), $urandom, drain);
                     made++;
                  end else if (roll < 95) begin
                     add_cmd(KIND_LIST, $urandom, drain);
                     made++;
                  end else begin
                     add_cmd(3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)),
                             $urandom, drain);
                  end
                  drain = 1'b0;
               end
            end
         endcase
         mode = $urandom_range(2, 0);
      end
      feed_total = feed_q.size();
   endfunction

   // Present commands; the sender's idle rate changes by thirds of the run.
   always @(posedge clock) begin
      logic          nxt_start;
      req_type       nxt_req;
      int            idle_pct;
      feed_item_type f;
      if (reset) begin
         start <= 1'b0;
         req   <= '0;
         owed  = 0;
      end else begin
         nxt_start = start;
         nxt_req   = req;
         if (rsp_strobe && owed > 0)
            owed--;
         if (start && !busy) begin
            owed += apply_deque_command(req);
            nxt_start = 1'b0;
         end
         if (issued < feed_total / 3)
            idle_pct = 28;
         else if (issued < 2 * feed_total / 3)
            idle_pct = 64;
         else
            idle_pct = 0;
         if (!nxt_start && feed_q.size() > 0) begin
            // hold a draining item until every owed result is back
            if (!(feed_q[0].drain && owed != 0) && $urandom_range(99, 0) >= idle_pct) begin
               f = feed_q.pop_front();
               nxt_start = 1'b1;
               nxt_req   = f.cmd;
               issued++;
            end
         end
         start <= nxt_start;
         req   <= nxt_req;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_rsp.size() == 0) begin
            flag_mismatch("result with nothing awaited", rsp.element, 32'h0);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp.status !== want.status)
               flag_mismatch("status", 32'(rsp.status), 32'(want.status));
            if (rsp.element_valid !== want.element_valid)
               flag_mismatch("element_valid", 32'(rsp.element_valid),
                             32'(want.element_valid));
            if (rsp.element !== want.element)
               flag_mismatch("element", rsp.element, want.element);
            if (rsp.last !== want.last)
               flag_mismatch("last", 32'(rsp.last), 32'(want.last));
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (feed_q.size() != 0 || start) @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DEQ_DEPTH + 8) @(posedge clock);
      if (error_count == 0)
         $display("tb_double_ended_queue: clean");
      else
         $display("tb_double_ended_queue: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_double_ended_queue: errors");
      $finish;
   end

endmodule
`default_nettype wire
